/* sv/gtm_pkg.sv */
// gtm_pkg: shared types, codes and constants of the GEMM core.
// No dependencies.
package gtm_pkg;

   localparam int MAX_DIM_DEF = 16;
   localparam int DIM_REG_W   = 5;
   localparam int SCALE_W     = 16;
   localparam int OPND_W      = 16;
   localparam int ELEM_W      = 32;
   localparam int IDX_IN_W    = 4;
   localparam int CMD_W       = 3;
   localparam int PADDR_W     = 5;
   localparam int PDATA_W     = 32;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_A  = 3'd0,
      CMD_LOAD_B  = 3'd1,
      CMD_LOAD_C  = 3'd2,
      CMD_COMPUTE = 3'd3,
      CMD_READ_C  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      REG_ROWS_M      = 3'd0,
      REG_COLS_N      = 3'd1,
      REG_INNER_K     = 3'd2,
      REG_TRANSPOSE_A = 3'd3,
      REG_TRANSPOSE_B = 3'd4,
      REG_ALPHA_SCALE = 3'd5,
      REG_BETA_SCALE  = 3'd6
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DOT,
      ST_FLUSH1,
      ST_FLUSH2,
      ST_SCALE,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [DIM_REG_W-1:0]      rows_m;
      logic [DIM_REG_W-1:0]      cols_n;
      logic [DIM_REG_W-1:0]      inner_k;
      logic                      transpose_a;
      logic                      transpose_b;
      logic signed [SCALE_W-1:0] alpha_scale;
      logic signed [SCALE_W-1:0] beta_scale;
   } cfg_type;

   typedef struct packed {
      logic issue;
      logic acc_clr;
      logic scale_en;
   } dp_ctl_type;

endpackage

/* sv/gtm_opnd_ram.sv */
// gtm_opnd_ram: operand store, bank A and bank B, one write port and a
// registered read of both banks per cycle. Depends on gtm_pkg.
module gtm_opnd_ram
   import gtm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic                                         wr_bank,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           waddr,
   input  logic signed [OPND_W-1:0]                     wdata,
   input  logic                                         re,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           raddr_a,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           raddr_b,
   output logic signed [OPND_W-1:0]                     rdata_a,
   output logic signed [OPND_W-1:0]                     rdata_b
);

   localparam int CELLS = MAX_DIM * MAX_DIM;

   logic [OPND_W-1:0] mem_a [CELLS];
   logic [OPND_W-1:0] mem_b [CELLS];
   logic [OPND_W-1:0] rd_a_ff;
   logic [OPND_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we && !wr_bank) begin
         mem_a[waddr] <= wdata;
      end
      if (we && wr_bank) begin
         mem_b[waddr] <= wdata;
      end
      if (re) begin
         rd_a_ff <= mem_a[raddr_a];
         rd_b_ff <= mem_b[raddr_b];
      end
   end

   assign rdata_a = signed'(rd_a_ff);
   assign rdata_b = signed'(rd_b_ff);

endmodule

/* sv/gtm_c_ram.sv */
// gtm_c_ram: store of C elements, one write port and one registered read port.
// Depends on gtm_pkg.
module gtm_c_ram
   import gtm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   waddr,
   input  logic signed [ELEM_W-1:0]             wdata,
   input  logic                                 re,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   raddr,
   output logic signed [ELEM_W-1:0]             rdata
);

   localparam int CELLS = MAX_DIM * MAX_DIM;

   logic [ELEM_W-1:0] mem_c [CELLS];
   logic [ELEM_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_c[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem_c[raddr];
      end
   end

   assign rdata = signed'(rd_ff);

endmodule

/* sv/gtm_dpath.sv */
// gtm_dpath: multiply-accumulate pipeline, alpha/beta scaling, rounding and
// saturation of one C element. Depends on gtm_pkg.
module gtm_dpath
   import gtm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_ctl_type               ctl,
   input  cfg_type                  cfg,
   input  logic signed [OPND_W-1:0] opnd_a,
   input  logic signed [OPND_W-1:0] opnd_b,
   input  logic signed [ELEM_W-1:0] c_old,
   output logic signed [ELEM_W-1:0] c_new,
   output logic                     c_sat
);

   localparam int PROD_W = 2 * OPND_W;
   localparam int DOT_W  = PROD_W + $clog2(MAX_DIM) + 1;
   localparam int TA_W   = DOT_W + SCALE_W;
   localparam int TC_W   = ELEM_W + SCALE_W;
   localparam int RND_SH = 8;
   localparam int SUM_W  = TA_W - RND_SH + 1;
   localparam int HI_W   = SUM_W - ELEM_W + 1;

   logic                     rd_vld_ff;
   logic                     prod_vld_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DOT_W-1:0]  acc_in;
   logic signed [DOT_W-1:0]  acc_ff;
   logic signed [TA_W-1:0]   term_a_in;
   logic signed [TA_W-1:0]   term_a_ff;
   logic signed [TC_W-1:0]   term_c_in;
   logic signed [TC_W-1:0]   term_c_ff;
   logic signed [TA_W-1:0]   rnd_a;
   logic signed [TC_W-1:0]   rnd_c;
   logic signed [SUM_W-1:0]  sum;
   logic [HI_W-1:0]          sum_hi;
   logic                     ovf_pos;
   logic                     ovf_neg;

   assign prod_in   = PROD_W'(opnd_a) * PROD_W'(opnd_b);
   assign acc_in    = acc_ff + DOT_W'(prod_ff);
   assign term_a_in = TA_W'(acc_ff) * TA_W'(cfg.alpha_scale);
   assign term_c_in = TC_W'(c_old) * TC_W'(cfg.beta_scale);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= ctl.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= prod_in;
      end
      if (ctl.acc_clr) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_in;
      end
      if (ctl.scale_en) begin
         term_a_ff <= term_a_in;
         term_c_ff <= term_c_in;
      end
   end

   // round half up, shifting out the 8 fraction bits of the Q8.8 scale factors
   assign rnd_a = (term_a_ff + TA_W'(128)) >>> RND_SH;
   assign rnd_c = (term_c_ff + TC_W'(128)) >>> RND_SH;
   assign sum   = SUM_W'(rnd_a) + SUM_W'(rnd_c);

   assign sum_hi  = sum[SUM_W-1:ELEM_W-1];
   assign ovf_pos = !sum[SUM_W-1] && (|sum_hi);
   assign ovf_neg = sum[SUM_W-1] && !(&sum_hi);

   always_comb begin
      if (ovf_pos) begin
         c_new = {1'b0, {(ELEM_W-1){1'b1}}};
      end else if (ovf_neg) begin
         c_new = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         c_new = sum[ELEM_W-1:0];
      end
   end

   assign c_sat = ovf_pos || ovf_neg;

`ifndef SYNTHESIS
   a_clr_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.acc_clr |-> (!prod_vld_ff && !rd_vld_ff))
      else $error("accumulator cleared with products in flight");
   a_scale_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.scale_en |-> (!prod_vld_ff && !rd_vld_ff))
      else $error("scaling started before dot product drained");
`endif

endmodule

/* sv/gtm_ctrl.sv */
// gtm_ctrl: command decode, compute sequencer and memory address generation.
// Depends on gtm_pkg.
module gtm_ctrl
   import gtm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [CMD_W-1:0]                     req_cmd,
   input  logic [IDX_IN_W-1:0]                  req_row_index,
   input  logic [IDX_IN_W-1:0]                  req_col_index,
   input  logic signed [ELEM_W-1:0]             req_value,
   input  cfg_type                              cfg,
   output logic                                 rsp_strobe,
   output logic                                 rsp_kind,
   output logic signed [ELEM_W-1:0]             rsp_value_res,
   output logic                                 rsp_saturated,
   output logic                                 op_we,
   output logic                                 op_wr_bank,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   op_waddr,
   output logic signed [OPND_W-1:0]             op_wdata,
   output logic                                 op_re,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   op_raddr_a,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   op_raddr_b,
   output logic                                 c_we,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   c_waddr,
   output logic signed [ELEM_W-1:0]             c_wdata,
   output logic                                 c_re,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   c_raddr,
   input  logic signed [ELEM_W-1:0]             c_rdata,
   output dp_ctl_type                           dp_ctl,
   input  logic signed [ELEM_W-1:0]             c_new,
   input  logic                                 c_sat
);

   localparam int CELLS  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam logic signed [ELEM_W-1:0] OPND_MAX = ELEM_W'((2 ** (OPND_W - 1)) - 1);
   localparam logic signed [ELEM_W-1:0] OPND_MIN = ELEM_W'(-(2 ** (OPND_W - 1)));

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_DIM + int'(c));
   endfunction

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic               sticky_ff, sticky_in;
   logic               rd_ok_ff;
   logic [CNT_W-1:0]   m_lim, n_lim, k_lim;
   logic               accept;
   cmd_type            cmd;
   logic               req_ok;
   logic [ADDR_W-1:0]  req_addr;
   logic [ADDR_W-1:0]  a_addr, b_addr, ci_addr;
   logic               i_last, j_last, k_last;
   logic signed [ELEM_W-1:0] clamped;

   assign m_lim = (int'(cfg.rows_m) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(cfg.rows_m);
   assign n_lim = (int'(cfg.cols_n) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(cfg.cols_n);
   assign k_lim = (int'(cfg.inner_k) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(cfg.inner_k);

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign cmd    = cmd_type'(req_cmd);

   assign req_ok   = (int'(req_row_index) < MAX_DIM) && (int'(req_col_index) < MAX_DIM);
   assign req_addr = cell_addr(IDX_W'(req_row_index), IDX_W'(req_col_index));

   assign a_addr  = cfg.transpose_a ? cell_addr(k_ff, i_ff) : cell_addr(i_ff, k_ff);
   assign b_addr  = cfg.transpose_b ? cell_addr(j_ff, k_ff) : cell_addr(k_ff, j_ff);
   assign ci_addr = cell_addr(i_ff, j_ff);

   assign k_last = ((CNT_W+1)'(k_ff) + (CNT_W+1)'(1) == (CNT_W+1)'(k_lim)) || (k_lim == '0);
   assign j_last = ((CNT_W+1)'(j_ff) + (CNT_W+1)'(1) == (CNT_W+1)'(n_lim));
   assign i_last = ((CNT_W+1)'(i_ff) + (CNT_W+1)'(1) == (CNT_W+1)'(m_lim));

   assign clamped = (req_value > OPND_MAX) ? OPND_MAX :
                    (req_value < OPND_MIN) ? OPND_MIN : req_value;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_COMPUTE: begin
                     state_in = ((m_lim == '0) || (n_lim == '0)) ? ST_DONE : ST_DOT;
                  end
                  CMD_READ_C: state_in = ST_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:   state_in = ST_IDLE;
         ST_DOT:    state_in = k_last ? ST_FLUSH1 : ST_DOT;
         ST_FLUSH1: state_in = ST_FLUSH2;
         ST_FLUSH2: state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_WRITE;
         ST_WRITE:  state_in = (i_last && j_last) ? ST_DONE : ST_DOT;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      op_we      = accept && req_ok && ((cmd == CMD_LOAD_A) || (cmd == CMD_LOAD_B));
      op_wr_bank = (cmd == CMD_LOAD_B);
      op_waddr   = req_addr;
      op_wdata   = clamped[OPND_W-1:0];
      op_re      = (state_ff == ST_DOT) && (k_lim != '0);
      op_raddr_a = a_addr;
      op_raddr_b = b_addr;

      c_re    = (accept && req_ok && (cmd == CMD_READ_C)) || (state_ff == ST_FLUSH1);
      c_raddr = (state_ff == ST_FLUSH1) ? ci_addr : req_addr;
      c_we    = (accept && req_ok && (cmd == CMD_LOAD_C)) || (state_ff == ST_WRITE);
      c_waddr = (state_ff == ST_WRITE) ? ci_addr : req_addr;
      c_wdata = (state_ff == ST_WRITE) ? c_new : req_value;

      dp_ctl.issue    = op_re;
      dp_ctl.acc_clr  = (accept && (cmd == CMD_COMPUTE)) || (state_ff == ST_WRITE);
      dp_ctl.scale_en = (state_ff == ST_SCALE);

      rsp_strobe    = (state_ff == ST_READ) || (state_ff == ST_DONE);
      rsp_kind      = (state_ff == ST_READ) ? KIND_READ : KIND_DONE;
      rsp_value_res = ((state_ff == ST_READ) && rd_ok_ff) ? c_rdata : '0;
      rsp_saturated = sticky_ff;
   end

   // loop counters and sticky flag
   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      sticky_in = sticky_ff;
      if (accept && (cmd == CMD_COMPUTE)) begin
         i_in      = '0;
         j_in      = '0;
         k_in      = '0;
         sticky_in = 1'b0;
      end else if (state_ff == ST_DOT) begin
         k_in = k_last ? '0 : k_ff + IDX_W'(1);
      end else if (state_ff == ST_WRITE) begin
         sticky_in = sticky_ff || c_sat;
         if (j_last) begin
            j_in = '0;
            i_in = i_ff + IDX_W'(1);
         end else begin
            j_in = j_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         sticky_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         sticky_ff <= sticky_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ok_ff <= req_ok;
      end
   end

`ifndef SYNTHESIS
   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe in consecutive cycles");
   a_c_port_conflict: assert property (@(posedge clock) disable iff (reset)
      !(c_we && c_re && (c_waddr == c_raddr)))
      else $error("C store read and write to the same entry in one cycle");
   a_busy_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_strobe))
      else $error("busy dropped without a result");
`endif

endmodule

/* sv/gemm_transpose_modes_core.sv */
// gemm_transpose_modes_core: top level of the fixed-point GEMM core with
// register file. Depends on gtm_pkg, gtm_ctrl, gtm_dpath, gtm_opnd_ram, gtm_c_ram.
//
// Computes C = beta*C + alpha*op(A)*op(B) over operand and result stores held
// in RAMs with a registered read. A transaction is taken when start is high
// and busy is low. Loads of A, B or C leave busy low, so they can be issued
// every cycle. A read of C returns its result on the cycle after acceptance.
// A compute keeps busy high until it reports in its final state, ST_DONE:
// each C element needs one operand-RAM read per inner step in ST_DOT, the
// drain states ST_FLUSH1 and ST_FLUSH2 of the multiply-accumulate pipeline,
// a scale state and a write-back state. Results are shown for one cycle on
// rsp_strobe and cannot be held off. Stores are not cleared at reset; reading
// an entry never written returns an undefined value.
module gemm_transpose_modes_core
   import gtm_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic [IDX_IN_W-1:0]      req_row_index,
   input  logic [IDX_IN_W-1:0]      req_col_index,
   input  logic signed [ELEM_W-1:0] req_value,
   output logic                     rsp_strobe,
   output logic                     rsp_kind,
   output logic signed [ELEM_W-1:0] rsp_value_res,
   output logic                     rsp_saturated,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [PADDR_W-1:0]       paddr,
   input  logic [PDATA_W-1:0]       pwdata,
   output logic [PDATA_W-1:0]       prdata,
   output logic                     pready
);

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

   cfg_type                  cfg_ff, cfg_in;
   csr_reg_type              csr_idx;
   logic                     csr_wr;

   logic                     op_we, op_wr_bank, op_re;
   logic [ADDR_W-1:0]        op_waddr, op_raddr_a, op_raddr_b;
   logic signed [OPND_W-1:0] op_wdata, op_rdata_a, op_rdata_b;
   logic                     c_we, c_re;
   logic [ADDR_W-1:0]        c_waddr, c_raddr;
   logic signed [ELEM_W-1:0] c_wdata, c_rdata, c_new;
   logic                     c_sat;
   dp_ctl_type               dp_ctl;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = csr_reg_type'(paddr[PADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_ROWS_M:      cfg_in.rows_m      = pwdata[DIM_REG_W-1:0];
            REG_COLS_N:      cfg_in.cols_n      = pwdata[DIM_REG_W-1:0];
            REG_INNER_K:     cfg_in.inner_k     = pwdata[DIM_REG_W-1:0];
            REG_TRANSPOSE_A: cfg_in.transpose_a = pwdata[0];
            REG_TRANSPOSE_B: cfg_in.transpose_b = pwdata[0];
            REG_ALPHA_SCALE: cfg_in.alpha_scale = pwdata[SCALE_W-1:0];
            REG_BETA_SCALE:  cfg_in.beta_scale  = pwdata[SCALE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ROWS_M:      prdata = {{(PDATA_W-DIM_REG_W){1'b0}}, cfg_ff.rows_m};
         REG_COLS_N:      prdata = {{(PDATA_W-DIM_REG_W){1'b0}}, cfg_ff.cols_n};
         REG_INNER_K:     prdata = {{(PDATA_W-DIM_REG_W){1'b0}}, cfg_ff.inner_k};
         REG_TRANSPOSE_A: prdata = {{(PDATA_W-1){1'b0}}, cfg_ff.transpose_a};
         REG_TRANSPOSE_B: prdata = {{(PDATA_W-1){1'b0}}, cfg_ff.transpose_b};
         REG_ALPHA_SCALE: prdata = {{(PDATA_W-SCALE_W){1'b0}}, cfg_ff.alpha_scale};
         REG_BETA_SCALE:  prdata = {{(PDATA_W-SCALE_W){1'b0}}, cfg_ff.beta_scale};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows_m      <= DIM_REG_W'(1);
         cfg_ff.cols_n      <= DIM_REG_W'(1);
         cfg_ff.inner_k     <= DIM_REG_W'(1);
         cfg_ff.transpose_a <= 1'b0;
         cfg_ff.transpose_b <= 1'b0;
         cfg_ff.alpha_scale <= SCALE_W'(256);
         cfg_ff.beta_scale  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gtm_ctrl #(
      .MAX_DIM (MAX_DIM)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_value     (req_value),
      .cfg           (cfg_ff),
      .rsp_strobe    (rsp_strobe),
      .rsp_kind      (rsp_kind),
      .rsp_value_res (rsp_value_res),
      .rsp_saturated (rsp_saturated),
      .op_we         (op_we),
      .op_wr_bank    (op_wr_bank),
      .op_waddr      (op_waddr),
      .op_wdata      (op_wdata),
      .op_re         (op_re),
      .op_raddr_a    (op_raddr_a),
      .op_raddr_b    (op_raddr_b),
      .c_we          (c_we),
      .c_waddr       (c_waddr),
      .c_wdata       (c_wdata),
      .c_re          (c_re),
      .c_raddr       (c_raddr),
      .c_rdata       (c_rdata),
      .dp_ctl        (dp_ctl),
      .c_new         (c_new),
      .c_sat         (c_sat)
   );

   gtm_dpath #(
      .MAX_DIM (MAX_DIM)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .ctl    (dp_ctl),
      .cfg    (cfg_ff),
      .opnd_a (op_rdata_a),
      .opnd_b (op_rdata_b),
      .c_old  (c_rdata),
      .c_new  (c_new),
      .c_sat  (c_sat)
   );

   gtm_opnd_ram #(
      .MAX_DIM (MAX_DIM)
   ) u_opnd_ram (
      .clock   (clock),
      .we      (op_we),
      .wr_bank (op_wr_bank),
      .waddr   (op_waddr),
      .wdata   (op_wdata),
      .re      (op_re),
      .raddr_a (op_raddr_a),
      .raddr_b (op_raddr_b),
      .rdata_a (op_rdata_a),
      .rdata_b (op_rdata_b)
   );

   gtm_c_ram #(
      .MAX_DIM (MAX_DIM)
   ) u_c_ram (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .re    (c_re),
      .raddr (c_raddr),
      .rdata (c_rdata)
   );

endmodule
